>>> rtl/core/htfd_pkg.sv
`timescale 1ns / 1ps

package htfd_pkg;

  // CRC-8 generator polynomial, MSB first
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Clears the two status bits of the data LSB
  localparam logic [7:0] STATUS_MASK = 8'hFC;

  // Conversion slopes and offsets, in hundredths
  localparam logic [14:0] TEMP_SPAN = 15'd17572;
  localparam logic [14:0] HUM_SPAN = 15'd12500;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4685;
  localparam logic signed [15:0] HUM_OFFSET = 16'sd600;

  // Measurement kind codes
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM = 1'b1;

  // Position of the next expected byte within a frame
  typedef enum logic [1:0] {
    POS_MSB = 2'd0,
    POS_LSB = 2'd1,
    POS_CRC = 2'd2
  } htfd_pos_t;

  // One received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       measure_kind;
    logic       frame_start;
  } htfd_in_t;

  // Completed frame, before conversion
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] raw_code;
    logic        kind;
  } htfd_frame_t;

  // One decoded reading
  typedef struct packed {
    logic               crc_ok;
    logic [15:0]        raw_code;
    logic signed [14:0] value_centi;
    logic               kind_out;
  } htfd_out_t;

  // Advance the CRC-8 by one byte, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    c = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/htfd_frame.sv
`timescale 1ns / 1ps

module htfd_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  htfd_pkg::htfd_in_t    in_data,
  input  logic                  advance,
  output logic                  frm_valid,
  output htfd_pkg::htfd_frame_t frm_data
);

  htfd_pkg::htfd_pos_t   pos_r, pos_nxt;
  logic [7:0]            crc_r, crc_nxt;
  logic [7:0]            high_r, high_nxt;
  logic [7:0]            low_r, low_nxt;
  logic                  frm_valid_r, frm_valid_nxt;
  htfd_pkg::htfd_frame_t frm_r, frm_nxt;
  logic                  emit;
  logic                  take_msb;

  // A start flag always opens a new frame
  assign take_msb = in_data.frame_start || (pos_r == htfd_pkg::POS_MSB);

  // Next byte position
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (take_msb) begin
        pos_nxt = htfd_pkg::POS_LSB;
      end else begin
        unique case (pos_r)
          htfd_pkg::POS_LSB: pos_nxt = htfd_pkg::POS_CRC;
          htfd_pkg::POS_CRC: pos_nxt = htfd_pkg::POS_MSB;
          default:           pos_nxt = htfd_pkg::POS_LSB;
        endcase
      end
    end
  end

  // Frame-complete strobe on the CRC byte
  always_comb begin
    emit = 1'b0;
    if (accept && !take_msb) begin
      unique case (pos_r)
        htfd_pkg::POS_CRC: emit = 1'b1;
        default:           emit = 1'b0;
      endcase
    end
  end

  // Data bytes and running CRC
  always_comb begin
    crc_nxt  = crc_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    if (accept) begin
      if (take_msb) begin
        high_nxt = in_data.rx_byte;
        crc_nxt  = htfd_pkg::crc8_update(8'h00, in_data.rx_byte);
      end else if (pos_r == htfd_pkg::POS_LSB) begin
        low_nxt = in_data.rx_byte;
        crc_nxt = htfd_pkg::crc8_update(crc_r, in_data.rx_byte);
      end else begin
        crc_nxt = 8'h00;
      end
    end
  end

  // Completed-frame register, drained by the conversion stage
  always_comb begin
    frm_nxt          = frm_r;
    frm_valid_nxt    = frm_valid_r;
    if (advance) begin
      frm_valid_nxt = 1'b0;
    end
    if (emit) begin
      frm_valid_nxt    = 1'b1;
      frm_nxt.crc_ok   = (crc_r == in_data.rx_byte);
      frm_nxt.raw_code = {high_r, low_r & htfd_pkg::STATUS_MASK};
      frm_nxt.kind     = in_data.measure_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= htfd_pkg::POS_MSB;
      crc_r       <= 8'h00;
      high_r      <= 8'h00;
      low_r       <= 8'h00;
      frm_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      frm_valid_r <= frm_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
  end

  assign frm_valid = frm_valid_r;
  assign frm_data  = frm_r;

endmodule

>>> rtl/core/htfd_convert.sv
`timescale 1ns / 1ps

module htfd_convert (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  frm_valid,
  input  htfd_pkg::htfd_frame_t frm_data,
  output logic                  advance,
  output logic                  out_valid,
  input  logic                  out_stall,
  output htfd_pkg::htfd_out_t   out_data
);

  logic                       out_valid_r, out_valid_nxt;
  htfd_pkg::htfd_out_t        out_r, out_nxt;
  logic [14:0]                span;
  logic signed [15:0]         offset;
  logic [30:0]                prod;
  logic [14:0]                scaled;
  logic signed [15:0]         value;

  // Output register is free when empty or being taken
  assign advance = !out_valid_r || !out_stall;

  // Select slope and offset by kind
  always_comb begin
    if (frm_data.kind == htfd_pkg::KIND_HUM) begin
      span   = htfd_pkg::HUM_SPAN;
      offset = htfd_pkg::HUM_OFFSET;
    end else begin
      span   = htfd_pkg::TEMP_SPAN;
      offset = htfd_pkg::TEMP_OFFSET;
    end
  end

  // Scale raw code: floor(span * raw / 65536) - offset
  assign prod   = 31'(frm_data.raw_code) * 31'(span);
  assign scaled = prod[30:16];
  assign value  = signed'({1'b0, scaled}) - offset;

  // Load the next reading
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = frm_valid;
      if (frm_valid) begin
        out_nxt.crc_ok      = frm_data.crc_ok;
        out_nxt.raw_code    = frm_data.raw_code;
        out_nxt.value_centi = frm_data.crc_ok ? value[14:0] : 15'sd0;
        out_nxt.kind_out    = frm_data.kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/humidity_temp_frame_decoder_core.sv
`timescale 1ns / 1ps

// Decoder for the three-byte measurement frame of a humidity/temperature
// sensor: data MSB, data LSB, CRC-8 (poly 0x31, init 0).
// Input channel (in_valid/in_stall/in_data) takes one byte per transaction
// together with the measurement kind and a frame-start flag; a start flag
// always opens a new frame and drops any partial one.
// Result channel (out_valid/out_stall/out_data) carries one reading per
// complete frame: CRC verdict, raw code with status bits cleared, value in
// hundredths (zero on CRC failure) and the kind of the CRC byte.
// Throughput: one byte per cycle while in_stall is low. The frame register
// loads at the edge that takes the CRC byte and the output register loads
// from it once free, so the reading passes through both registers; the one
// 16x15 multiply by the selected slope in the conversion sets the path.
// When the receiver stalls, the output register holds its reading and the
// frame register can hold one more; in_stall rises only when both are full,
// and while it is high no byte is taken.
// Synchronous reset clears the byte position, CRC, data bytes and both
// valid flags.

module humidity_temp_frame_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  htfd_pkg::htfd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output htfd_pkg::htfd_out_t out_data
);

  logic                  accept;
  logic                  advance;
  logic                  frm_valid;
  htfd_pkg::htfd_frame_t frm_data;

  // Hold the input only when a finished frame cannot move on
  assign in_stall = frm_valid && !advance;
  assign accept   = in_valid && !in_stall;

  htfd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .advance   (advance),
    .frm_valid (frm_valid),
    .frm_data  (frm_data)
  );

  htfd_convert u_convert (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm_valid),
    .frm_data  (frm_data),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/htfd_checker.sv
`timescale 1ns / 1ps

module htfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input htfd_pkg::htfd_out_t out_data
);

  // Stalled reading holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled reading changed");

  // Input is held back only behind a stalled, full output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Failed CRC gives a zero value
  a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.crc_ok |-> out_data.value_centi == 15'sd0)
    else $error("nonzero value on CRC failure");

  // Status bits are cleared in the raw code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.raw_code[1:0] == 2'b00)
    else $error("status bits present in raw code");

  // Reset empties the result channel
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending after reset");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
